// ----- rtl/cwu_pkg.sv -----
// ----------------------------------------------------------------------------
// cwu_pkg
// Types, constants and helpers shared by the congestion window update block.
// ----------------------------------------------------------------------------
package cwu_pkg;

  localparam int unsigned CFG_ADDR_W   = 3;
  localparam int unsigned CFG_DATA_W   = 32;

  localparam logic [15:0] MSS_RESET    = 16'd1024;
  localparam logic [31:0] CWND_RESET   = 32'(2 * 1024);
  localparam logic [31:0] SSTH_RESET   = 32'(10 * 1024);
  localparam int unsigned BUFFER_BYTES = 65536;
  localparam logic [16:0] PEER_RESET   = 17'(BUFFER_BYTES % (1 << 17));
  localparam logic [1:0]  DUP_ACK_LIMIT = 2'd3;
  localparam logic [31:0] CWND_MAX     = 32'hFFFF_FFFF;
  localparam logic [31:0] PTR_RESET    = 32'hFFFF_FFFF;  // -1

  localparam int unsigned DIV_STEPS    = 32;
  localparam int unsigned DIV_CNT_W    = $clog2(DIV_STEPS);

  // register index, taken from paddr above the byte lanes
  typedef enum logic [0:0] {
    REG_SEGMENT_SIZE = 1'b0,
    REG_UNUSED       = 1'b1
  } cwu_reg_e;

  typedef struct packed {
    logic load_item;
    logic mul_load;
    logic div_step;
    logic commit;
  } cwu_cmd_t;

  typedef struct packed {
    logic need_div;
  } cwu_status_t;

  function automatic logic [31:0] halve_floor(input logic [31:0] t, input logic [15:0] mss);
    logic [31:0] h;
    logic [31:0] f;
    h = t >> 1;
    f = {16'b0, mss};
    return (h > f) ? h : f;
  endfunction

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? CWND_MAX : s[31:0];
  endfunction

endpackage

// ----- rtl/cwu_if.sv -----
// ----------------------------------------------------------------------------
// cwu_in_if / cwu_out_if
// Valid/ready channels for events in and window results out.
// ----------------------------------------------------------------------------
interface cwu_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [30:0] ack_number;
  logic [16:0] peer_window;

  modport source (output valid, func, ack_number, peer_window, input ready);
  modport sink   (input valid, func, ack_number, peer_window, output ready);
endinterface

interface cwu_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] congestion_window;
  logic [31:0] slow_start_threshold;
  logic [16:0] send_window;
  logic [31:0] released_bytes;
  logic        fast_retransmit;
  logic signed [31:0] acked_position;
  logic signed [31:0] sent_position;

  modport source (output valid, congestion_window, slow_start_threshold, send_window,
                  released_bytes, fast_retransmit, acked_position, sent_position,
                  input ready);
  modport sink   (input valid, congestion_window, slow_start_threshold, send_window,
                  released_bytes, fast_retransmit, acked_position, sent_position,
                  output ready);
endinterface

// ----- rtl/cwu_apb_regs.sv -----
// ----------------------------------------------------------------------------
// cwu_apb_regs
// APB register file holding the segment size.
// ----------------------------------------------------------------------------
module cwu_apb_regs (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [cwu_pkg::CFG_ADDR_W-1:0]       paddr,
  input  logic [cwu_pkg::CFG_DATA_W-1:0]       pwdata,
  output logic [cwu_pkg::CFG_DATA_W-1:0]       prdata,
  output logic                                 pready,
  output logic [15:0]                          mss_o
);

  logic [15:0]       mss_q;
  cwu_pkg::cwu_reg_e reg_sel;
  logic              wr_en;

  assign reg_sel = cwu_pkg::cwu_reg_e'(paddr[cwu_pkg::CFG_ADDR_W-1]);
  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mss_q <= cwu_pkg::MSS_RESET;
    end else if (wr_en && reg_sel == cwu_pkg::REG_SEGMENT_SIZE) begin
      mss_q <= pwdata[15:0];
    end
  end

  always_comb begin
    unique case (reg_sel)
      cwu_pkg::REG_SEGMENT_SIZE: prdata = {16'b0, mss_q};
      default:                   prdata = '0;
    endcase
  end

  assign mss_o = mss_q;

endmodule

// ----- rtl/cwu_ctrl.sv -----
// ----------------------------------------------------------------------------
// cwu_ctrl
// Sequencer: load event, evaluate, optional multiply and divide, commit.
// ----------------------------------------------------------------------------
module cwu_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  cwu_pkg::cwu_status_t status_i,
  output cwu_pkg::cwu_cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_MUL,
    ST_DIV,
    ST_FIN
  } state_e;

  state_e                         state_q;
  logic [cwu_pkg::DIV_CNT_W-1:0]  cnt_q;
  logic                           out_valid_q;
  logic                           out_free;
  logic                           commit;

  // result register is free when empty or being drained this cycle
  assign out_free = !out_valid_q || out_ready_i;
  assign commit   = out_free &&
                    ((state_q == ST_EVAL && !status_i.need_div) || state_q == ST_FIN);

  assign in_ready_o        = (state_q == ST_IDLE);
  assign out_valid_o       = out_valid_q;
  assign cmd_o.load_item   = (state_q == ST_IDLE) && in_valid_i;
  assign cmd_o.mul_load    = (state_q == ST_MUL);
  assign cmd_o.div_step    = (state_q == ST_DIV);
  assign cmd_o.commit      = commit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) state_q <= ST_EVAL;
        end
        ST_EVAL: begin
          if (status_i.need_div) begin
            state_q <= ST_MUL;
          end else if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        ST_MUL: begin
          cnt_q   <= '0;
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == cwu_pkg::DIV_CNT_W'(cwu_pkg::DIV_STEPS - 1)) state_q <= ST_FIN;
        end
        ST_FIN: begin
          if (out_free) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/cwu_dp.sv -----
// ----------------------------------------------------------------------------
// cwu_dp
// Window state, event decode, restoring divider and result register.
// ----------------------------------------------------------------------------
module cwu_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cwu_pkg::cwu_cmd_t    cmd_i,
  output cwu_pkg::cwu_status_t status_o,
  input  logic [15:0]          mss_i,
  input  logic                 func_i,
  input  logic [30:0]          ack_number_i,
  input  logic [16:0]          peer_window_i,
  output logic [31:0]          congestion_window_o,
  output logic [31:0]          slow_start_threshold_o,
  output logic [16:0]          send_window_o,
  output logic [31:0]          released_bytes_o,
  output logic                 fast_retransmit_o,
  output logic signed [31:0]   acked_position_o,
  output logic signed [31:0]   sent_position_o
);

  // event held for the duration of the item
  logic        func_q;
  logic [30:0] ack_q;
  logic [16:0] pw_q;

  // window state
  logic [31:0]        cwnd_q, cwnd_d;
  logic [31:0]        ssth_q, ssth_d;
  logic [16:0]        peer_q, peer_d;
  logic signed [31:0] acked_q, acked_d;
  logic signed [31:0] sent_q, sent_d;
  logic [1:0]         dup_q, dup_d;

  // divider: dividend shifts out, quotient shifts in
  logic [31:0] dvd_q, dvd_d;
  logic [31:0] rem_q, rem_d;
  logic [32:0] rem_sh;
  logic        q_bit;
  logic [31:0] mss_sq;

  logic signed [31:0] ack_s;
  logic        is_dup, is_new;
  logic        slow_start;
  logic [1:0]  dup_inc;
  logic [31:0] ssth_half;
  logic [31:0] grow_add;
  logic [31:0] released;
  logic        fast;
  logic [16:0] swnd;

  assign ack_s      = signed'({1'b0, ack_q});
  assign is_dup     = !func_q && (ack_s == acked_q);
  assign is_new     = !func_q && (ack_s > acked_q);
  assign slow_start = cwnd_q < ssth_q;
  assign dup_inc    = dup_q + 2'd1;
  assign ssth_half  = cwu_pkg::halve_floor(ssth_q, mss_i);

  assign status_o.need_div = is_new && !slow_start && (cwnd_q != '0);

  assign mss_sq = 32'(mss_i) * 32'(mss_i);
  assign rem_sh = {rem_q, dvd_q[31]};
  assign q_bit  = rem_sh >= {1'b0, cwnd_q};

  always_comb begin
    dvd_d = dvd_q;
    rem_d = rem_q;
    if (cmd_i.mul_load) begin
      dvd_d = mss_sq;
      rem_d = '0;
    end else if (cmd_i.div_step) begin
      dvd_d = {dvd_q[30:0], q_bit};
      rem_d = q_bit ? 32'(rem_sh - {1'b0, cwnd_q}) : rem_sh[31:0];
    end
  end

  // slow start adds a segment, avoidance adds the quotient
  assign grow_add = slow_start ? {16'b0, mss_i} : dvd_q;

  always_comb begin
    cwnd_d   = cwnd_q;
    ssth_d   = ssth_q;
    peer_d   = peer_q;
    acked_d  = acked_q;
    sent_d   = sent_q;
    dup_d    = dup_q;
    released = '0;
    fast     = 1'b0;
    if (func_q) begin
      ssth_d = ssth_half;
      cwnd_d = {16'b0, mss_i};
    end else begin
      peer_d = pw_q;
      if (is_dup) begin
        dup_d = dup_inc;
        if (dup_inc >= cwu_pkg::DUP_ACK_LIMIT) begin
          ssth_d = ssth_half;
          cwnd_d = ssth_half;
          dup_d  = '0;
          fast   = 1'b1;
        end
      end else if (is_new) begin
        dup_d    = '0;
        released = 32'(ack_s - acked_q);
        acked_d  = ack_s;
        if (ack_s > sent_q) sent_d = ack_s;
        if (!slow_start && cwnd_q == '0) begin
          cwnd_d = cwu_pkg::CWND_MAX;
        end else begin
          cwnd_d = cwu_pkg::sat_add(cwnd_q, grow_add);
        end
      end
    end
  end

  assign swnd = (cwnd_d < {15'b0, peer_d}) ? cwnd_d[16:0] : peer_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cwnd_q  <= cwu_pkg::CWND_RESET;
      ssth_q  <= cwu_pkg::SSTH_RESET;
      peer_q  <= cwu_pkg::PEER_RESET;
      acked_q <= signed'(cwu_pkg::PTR_RESET);
      sent_q  <= signed'(cwu_pkg::PTR_RESET);
      dup_q   <= '0;
    end else if (cmd_i.commit) begin
      cwnd_q  <= cwnd_d;
      ssth_q  <= ssth_d;
      peer_q  <= peer_d;
      acked_q <= acked_d;
      sent_q  <= sent_d;
      dup_q   <= dup_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      func_q <= func_i;
      ack_q  <= ack_number_i;
      pw_q   <= peer_window_i;
    end
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    if (cmd_i.commit) begin
      congestion_window_o    <= cwnd_d;
      slow_start_threshold_o <= ssth_d;
      send_window_o          <= swnd;
      released_bytes_o       <= released;
      fast_retransmit_o      <= fast;
      acked_position_o       <= acked_d;
      sent_position_o        <= sent_d;
    end
  end

endmodule

// ----- rtl/congestion_window_update.sv -----
// ----------------------------------------------------------------------------
// congestion_window_update
// Sender-side congestion window engine, Tahoe style.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one event per beat: func 0 for an ack (with ack_number and
//   the peer's advertised window), func 1 for a receive timeout.
//   out_o returns one result beat per event: cwnd, ssthresh, send window,
//   released bytes, fast retransmit flag and the acked/sent positions.
//   The APB port holds segment_size at byte address 0; write it while idle.
// Sequence:
//   An event is taken in ST_IDLE and evaluated in ST_EVAL. A new ack in
//   congestion avoidance also computes MSS*MSS/cwnd: a multiply load in
//   ST_MUL, a 32-step restoring divider in ST_DIV, then a commit in ST_FIN.
//   The divider sets the worst-case rate.
// Reset:
//   cwnd 2048, ssthresh 10240, peer window 65536, positions -1, duplicate
//   count 0, segment_size 1024. No result is pending.
// Back-pressure:
//   The result sits in an output register; the next event is accepted and
//   processed while it waits, and its commit holds until out_o drains.
// ----------------------------------------------------------------------------
module congestion_window_update (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  cwu_in_if.sink                         in_i,
  cwu_out_if.source                      out_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [cwu_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [cwu_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [cwu_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);

  logic                 [15:0] mss;
  cwu_pkg::cwu_cmd_t    cmd;
  cwu_pkg::cwu_status_t status;

  cwu_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .mss_o   (mss)
  );

  cwu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  cwu_dp u_dp (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .cmd_i                  (cmd),
    .status_o               (status),
    .mss_i                  (mss),
    .func_i                 (in_i.func),
    .ack_number_i           (in_i.ack_number),
    .peer_window_i          (in_i.peer_window),
    .congestion_window_o    (out_o.congestion_window),
    .slow_start_threshold_o (out_o.slow_start_threshold),
    .send_window_o          (out_o.send_window),
    .released_bytes_o       (out_o.released_bytes),
    .fast_retransmit_o      (out_o.fast_retransmit),
    .acked_position_o       (out_o.acked_position),
    .sent_position_o        (out_o.sent_position)
  );

endmodule

// ----- tb/tb_congestion_window_update.sv -----
// ----------------------------------------------------------------------------
// tb_congestion_window_update
// Self-checking bench for the Tahoe-style congestion window engine: events
// go in on the input channel, and every result beat is checked against a
// cycle-free window tracker. segment_size is changed between phases over APB.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_congestion_window_update;

  localparam int unsigned  LONG_HOLD    = 300;
  localparam int unsigned  DRAIN_CYCLES = 40;
  localparam logic [30:0]  ACK_TOP      = 31'h7FFF_FFFF;
  localparam logic [16:0]  WINDOW_TOP   = 17'd65536;

  typedef enum logic {
    EV_ACK     = 1'b0,
    EV_TIMEOUT = 1'b1
  } cw_event_e;

  typedef struct packed {
    logic [31:0]        cwnd;
    logic [31:0]        ssthresh;
    logic [16:0]        send_window;
    logic [31:0]        released;
    logic               fast_rexmit;
    logic signed [31:0] acked;
    logic signed [31:0] sent;
  } window_result_t;

  // Tracks the sender's window state and queues the expected result beats.
  class cwnd_tracker;
    logic [15:0]    mss;
    logic [31:0]    cwnd;
    logic [31:0]    ssthresh;
    logic [16:0]    peer_window;
    longint         acked_ptr;
    longint         sent_ptr;
    logic [1:0]     dup_run;
    int unsigned    failures;
    window_result_t expected_windows[$];

    function new();
      mss         = cwu_pkg::MSS_RESET;
      cwnd        = 32'd2048;
      ssthresh    = 32'd10240;
      peer_window = 17'(cwu_pkg::BUFFER_BYTES);
      acked_ptr   = -1;
      sent_ptr    = -1;
      dup_run     = 2'd0;
      failures    = 0;
    endfunction

    function void set_segment_size(logic [15:0] value);
      mss = value;
    endfunction

    function int unsigned pending();
      return expected_windows.size();
    endfunction

    function logic [31:0] halve_with_floor(logic [31:0] t);
      logic [31:0] h;
      h = t >> 1;
      return (h > {16'b0, mss}) ? h : {16'b0, mss};
    endfunction

    function logic [31:0] grow_saturated(logic [31:0] a, logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function void apply_event(cw_event_e kind, logic [30:0] ack, logic [16:0] pw);
      window_result_t r;
      longint         a;
      logic [31:0]    sq;
      r = '0;
      a = longint'({33'b0, ack});
      if (kind == EV_TIMEOUT) begin
        ssthresh = halve_with_floor(ssthresh);
        cwnd     = {16'b0, mss};
      end else begin
        peer_window = pw;
        if (a == acked_ptr) begin
          dup_run = dup_run + 2'd1;
          if (dup_run >= cwu_pkg::DUP_ACK_LIMIT) begin
            ssthresh      = halve_with_floor(ssthresh);
            cwnd          = ssthresh;
            dup_run       = 2'd0;
            r.fast_rexmit = 1'b1;
          end
        end else if (a > acked_ptr) begin
          dup_run    = 2'd0;
          r.released = 32'(a - acked_ptr);
          acked_ptr  = a;
          if (acked_ptr > sent_ptr) sent_ptr = acked_ptr;
          if (cwnd < ssthresh) begin
            cwnd = grow_saturated(cwnd, {16'b0, mss});
          end else if (cwnd == 32'd0) begin
            cwnd = 32'hFFFF_FFFF;
          end else begin
            sq   = {16'b0, mss} * {16'b0, mss};
            cwnd = grow_saturated(cwnd, sq / cwnd);
          end
        end
        // stale ack: only the peer window is taken
      end
      r.cwnd        = cwnd;
      r.ssthresh    = ssthresh;
      r.send_window = (cwnd < {15'b0, peer_window}) ? cwnd[16:0] : peer_window;
      r.acked       = acked_ptr[31:0];
      r.sent        = sent_ptr[31:0];
      expected_windows.insert(expected_windows.size(), r);
    endfunction

    function void compare_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
      if (exp_v !== got_v) begin
        failures++;
        $error("%s: expected %0h, got %0h", name, exp_v, got_v);
      end
    endfunction

    function void check_window(window_result_t got);
      window_result_t e;
      if (expected_windows.size() == 0) begin
        failures++;
        $error("result beat with no event outstanding");
        return;
      end
      e = expected_windows[0];
      expected_windows.delete(0);
      compare_field("congestion_window", e.cwnd, got.cwnd);
      compare_field("slow_start_threshold", e.ssthresh, got.ssthresh);
      compare_field("send_window", 32'(e.send_window), 32'(got.send_window));
      compare_field("released_bytes", e.released, got.released);
      compare_field("fast_retransmit", 32'(e.fast_rexmit), 32'(got.fast_rexmit));
      compare_field("acked_position", e.acked, got.acked);
      compare_field("sent_position", e.sent, got.sent);
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [cwu_pkg::CFG_ADDR_W-1:0] paddr;
  logic [cwu_pkg::CFG_DATA_W-1:0] pwdata;
  logic [cwu_pkg::CFG_DATA_W-1:0] prdata;
  logic        pready;

  cwu_in_if  in_ch();
  cwu_out_if out_ch();

  cwnd_tracker tracker = new();

  longint      last_ack = -1;   // highest ack offered so far
  bit          bursty = 1'b1;
  bit          long_hold_req = 1'b0;
  int unsigned rx_hold = 0;

  congestion_window_update uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_ch),
    .out_o   (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // beat monitor: events into the tracker, results against it
  always @(posedge clk_i) begin : beat_monitor
    window_result_t got;
    if (in_ch.valid && in_ch.ready)
      tracker.apply_event(cw_event_e'(in_ch.func), in_ch.ack_number, in_ch.peer_window);
    if (out_ch.valid && out_ch.ready) begin
      got.cwnd        = out_ch.congestion_window;
      got.ssthresh    = out_ch.slow_start_threshold;
      got.send_window = out_ch.send_window;
      got.released    = out_ch.released_bytes;
      got.fast_rexmit = out_ch.fast_retransmit;
      got.acked       = out_ch.acked_position;
      got.sent        = out_ch.sent_position;
      tracker.check_window(got);
    end
  end

  // result side: random stall bursts, plus one long hold on request
  initial begin : result_sink
    out_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (rx_hold != 0) begin
        out_ch.ready <= 1'b0;
        rx_hold--;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        rx_hold       = LONG_HOLD - 1;
        out_ch.ready <= 1'b0;
      end else if (bursty && $urandom_range(0, 5) == 0) begin
        rx_hold       = $urandom_range(0, 7);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_event(cw_event_e kind, logic [30:0] ack, logic [16:0] pw);
    if (bursty && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    in_ch.valid       <= 1'b1;
    in_ch.func        <= kind;
    in_ch.ack_number  <= ack;
    in_ch.peer_window <= pw;
    if (kind == EV_ACK && longint'({33'b0, ack}) > last_ack) last_ack = longint'({33'b0, ack});
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  task automatic apb_access(logic write, cwu_pkg::cwu_reg_e idx, logic [31:0] wdata,
                            output logic [31:0] rdata);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata    = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_mss(logic [15:0] value);
    logic [31:0] rd;
    apb_access(1'b1, cwu_pkg::REG_SEGMENT_SIZE, {16'b0, value}, rd);
    tracker.set_segment_size(value);
    apb_access(1'b0, cwu_pkg::REG_SEGMENT_SIZE, 32'd0, rd);
    tracker.compare_field("segment_size readback", {16'b0, value}, rd);
  endtask

  // let the last beat land in the tracker, then wait for all results
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [16:0] pick_window();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return WINDOW_TOP;
    if (r == 1) return 17'($urandom);
    return 17'($urandom_range(0, 65536));
  endfunction

  // mostly well-formed ack streams: advances, duplicate runs, some stale and timeouts
  task automatic random_traffic(int unsigned n);
    int unsigned sent_cnt;
    int unsigned r;
    int unsigned run;
    longint      nxt;
    sent_cnt = 0;
    while (sent_cnt < n) begin
      r = $urandom_range(0, 99);
      if (r < 42) begin
        if ($urandom_range(0, 9) == 0) nxt = last_ack + $urandom_range(1, 1 << 22);
        else nxt = last_ack + $urandom_range(1, 3000);
        if (nxt >= longint'(ACK_TOP)) nxt = (last_ack < 0) ? 0 : last_ack;
        send_event(EV_ACK, 31'(nxt), pick_window());
        sent_cnt++;
      end else if (r < 68) begin
        run = $urandom_range(1, 4);
        repeat (run) begin
          send_event(EV_ACK, (last_ack < 0) ? 31'd0 : 31'(last_ack), pick_window());
          sent_cnt++;
        end
      end else if (r < 82) begin
        if (last_ack > 0) send_event(EV_ACK, 31'($urandom_range(0, 32'(last_ack - 1))),
                                     pick_window());
        else send_event(EV_TIMEOUT, 31'($urandom), 17'($urandom));
        sent_cnt++;
      end else begin
        // timeout fields are don't-care: full random bits
        send_event(EV_TIMEOUT, 31'($urandom), 17'($urandom));
        sent_cnt++;
      end
    end
  endtask

  initial begin : stimulus
    rst_ni            <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.func        <= EV_ACK;
    in_ch.ack_number  <= '0;
    in_ch.peer_window <= '0;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: first ack from -1, dup cut, stale, timeout, SS into CA
    send_event(EV_ACK, 31'd0, 17'd0);
    send_event(EV_ACK, 31'd0, WINDOW_TOP);
    send_event(EV_ACK, 31'd0, 17'h1FFFF);
    send_event(EV_ACK, 31'd0, 17'd4000);
    send_event(EV_ACK, 31'd1000, WINDOW_TOP);
    send_event(EV_ACK, 31'd500, 17'd3000);
    send_event(EV_TIMEOUT, ACK_TOP, 17'h1FFFF);
    send_event(EV_ACK, 31'd2000, WINDOW_TOP);
    send_event(EV_ACK, 31'd3000, WINDOW_TOP);
    send_event(EV_ACK, 31'd4000, WINDOW_TOP);
    send_event(EV_ACK, 31'd5000, WINDOW_TOP);
    // new ack clears the duplicate run
    send_event(EV_ACK, 31'd5000, 17'd1500);
    send_event(EV_ACK, 31'd5000, 17'd1500);
    send_event(EV_ACK, 31'd6000, 17'd1500);
    send_event(EV_ACK, 31'd6000, 17'd1500);
    send_event(EV_ACK, 31'd6000, 17'd1500);
    send_event(EV_ACK, 31'd6000, 17'd1500);
    // stale and timeout leave the duplicate run alone
    send_event(EV_ACK, 31'd6000, 17'd2500);
    send_event(EV_ACK, 31'd10, 17'd2500);
    send_event(EV_TIMEOUT, 31'd0, 17'd0);
    send_event(EV_ACK, 31'd6000, 17'd2500);
    send_event(EV_ACK, 31'd6000, 17'd2500);
    random_traffic(300);
    settle();

    set_mss(16'd1);
    random_traffic(150);
    settle();

    set_mss(16'hFFFF);
    long_hold_req = 1'b1;
    random_traffic(150);
    settle();

    // zero segment size: enough timeouts to take ssthresh to zero, then CA at cwnd 0
    set_mss(16'd0);
    repeat (20) send_event(EV_TIMEOUT, 31'($urandom), 17'($urandom));
    random_traffic(100);
    settle();

    set_mss(16'd536);
    random_traffic(150);
    settle();

    set_mss(16'($urandom_range(1, 65535)));
    random_traffic(150);
    settle();

    set_mss(16'd1460);
    bursty = 1'b0;
    random_traffic(120);
    send_event(EV_ACK, ACK_TOP, WINDOW_TOP);
    send_event(EV_ACK, ACK_TOP, 17'd100);
    send_event(EV_ACK, ACK_TOP, 17'd200);
    send_event(EV_ACK, ACK_TOP, 17'd300);
    send_event(EV_ACK, 31'd0, 17'h1FFFF);
    send_event(EV_TIMEOUT, ACK_TOP, 17'd0);
    settle();

    if (tracker.failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
